// ----- design/lpht_pkg.sv -----
// Shared widths, status codes and state type for the linear-probe hash table.
package lpht_pkg;

    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int SIZE_W = 5;
    localparam int CNT_W  = 5;
    localparam int ST_W   = 2;
    localparam int TDATA_W = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    typedef enum logic [ST_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        MODE_INSERT = 1'b0,
        MODE_SEARCH = 1'b1
    } mode_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_INS  = 5'b00100,
        S_SRCH = 5'b01000,
        S_RESP = 5'b10000
    } fsm_t;

endpackage

// ----- design/lpht_mod.sv -----
// Bit-serial restoring remainder unit: key modulo table size, one key bit per cycle.
module lpht_mod (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lpht_pkg::KEY_W-1:0] dividend,
    input  logic [lpht_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output logic [lpht_pkg::SIZE_W-1:0] remainder
);
    import lpht_pkg::*;

    localparam int CW = $clog2(KEY_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [KEY_W-1:0]  dvd_reg, dvd_next;
    logic [SIZE_W-1:0] div_reg, div_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;

    always_comb begin
        trial = {rem_reg, dvd_reg[KEY_W-1]};
        diff  = trial - {1'b0, div_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CW'(KEY_W - 1);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // subtract when the partial remainder reaches the divisor
            rem_next = (trial >= {1'b0, div_reg}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            dvd_next = {dvd_reg[KEY_W-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/lpht_mem.sv -----
// Single-port-write, registered-read slot memory holding key and value.
module lpht_mem #(
    parameter int DEPTH = 16,
    parameter int DW    = 63
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/linear_probe_hash_table_top.sv -----
// Top level of the open-addressing hash table with linear probing.
// Sequence: the remainder of the key modulo the effective table size is formed first, then P
//   slots are probed, P being the probe count (1 up to the effective table size). An insert
//   into a table already counted full skips the probes.
// Throughput: one item at a time; the next item is accepted only once the last result is
//   loaded into the output register, later while the result item waits on m_tready.
// Reset: synchronous active-low; clears slot valid bits, count and table size (16).
module linear_probe_hash_table_top #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // config: table_size
    input  logic                         cfg_we,
    input  logic [lpht_pkg::SIZE_W-1:0]  cfg_wdata,
    // input item
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lpht_pkg::TDATA_W-1:0] s_tdata,   // [30:0] key, [62:31] value, [63] zero
    input  logic                         s_tuser,   // [0] mode
    // result item
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lpht_pkg::VAL_W-1:0]   m_tdata,   // [31:0] found_value
    output logic [lpht_pkg::ST_W-1:0]    m_tuser    // [1:0] status
);
    import lpht_pkg::*;

    // Slots beyond 31 are never reached, since table_size is five bits wide.
    localparam int VLD_N = (SLOT_COUNT < 31) ? SLOT_COUNT : 31;
    localparam int VW    = $clog2(VLD_N);
    localparam int AW    = $clog2(SLOT_COUNT);
    localparam int DW    = KEY_W + VAL_W;
    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(VLD_N);

    fsm_t               state_reg, state_next;
    logic [SIZE_W-1:0]  tsize_reg;
    logic [SIZE_W-1:0]  eff_size;
    logic [VLD_N-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               mode_reg, mode_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [SIZE_W-1:0]  pos_reg, pos_next;
    logic [SIZE_W-1:0]  n_reg, n_next;
    logic [SIZE_W-1:0]  pos_inc;
    logic               last_probe;
    logic               slot_vld;
    status_t            res_st_reg, res_st_next;
    logic [VAL_W-1:0]   res_val_reg, res_val_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_st_reg, m_st_next;
    logic [VAL_W-1:0]   m_val_reg, m_val_next;

    logic               mod_start;
    logic               mod_done;
    logic [SIZE_W-1:0]  mod_rem;
    logic               mem_we;
    logic [DW-1:0]      mem_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]   rd_val;
    logic               in_fire;

    // Size zero acts as one; anything past the slot count acts as the slot count.
    always_comb begin
        if (tsize_reg == '0) begin
            eff_size = SIZE_W'(1);
        end else if (tsize_reg > SIZE_CAP) begin
            eff_size = SIZE_CAP;
        end else begin
            eff_size = tsize_reg;
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign mod_start  = in_fire;
    assign pos_inc    = (pos_reg + 1'b1 == eff_size) ? '0 : pos_reg + 1'b1;
    assign last_probe = (n_reg == eff_size - 1'b1);
    assign slot_vld   = valid_reg[VW'(pos_reg)];
    assign rd_key     = mem_rdata[KEY_W-1:0];
    assign rd_val     = mem_rdata[DW-1:KEY_W];

    // Main sequencer: remainder, then walk slots one per cycle.
    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        count_next   = count_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        n_next       = n_reg;
        res_st_next  = res_st_reg;
        res_val_next = res_val_reg;
        mem_we       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    mode_next  = s_tuser;
                    key_next   = s_tdata[KEY_W-1:0];
                    val_next   = s_tdata[DW-1:KEY_W];
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    pos_next     = mod_rem;
                    n_next       = '0;
                    res_val_next = '0;
                    if (mode_reg == MODE_SEARCH) begin
                        state_next = S_SRCH;
                    end else if (count_reg >= eff_size) begin
                        res_st_next = ST_FULL;
                        state_next  = S_RESP;
                    end else begin
                        state_next = S_INS;
                    end
                end
            end
            S_INS: begin
                if (!slot_vld) begin
                    // claim the empty slot
                    mem_we                    = 1'b1;
                    valid_next[VW'(pos_reg)]  = 1'b1;
                    count_next                = count_reg + 1'b1;
                    res_st_next               = ST_INSERTED;
                    state_next                = S_RESP;
                end else if (last_probe) begin
                    res_st_next = ST_FULL;
                    state_next  = S_RESP;
                end else begin
                    pos_next = pos_inc;
                    n_next   = n_reg + 1'b1;
                end
            end
            S_SRCH: begin
                // read data for pos_reg arrives this cycle
                if (!slot_vld) begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end else if (rd_key == key_reg) begin
                    res_st_next  = ST_FOUND;
                    res_val_next = rd_val;
                    state_next   = S_RESP;
                end else if (last_probe) begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end else begin
                    pos_next = pos_inc;
                    n_next   = n_reg + 1'b1;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load the finished result once the slot is free.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_st_next    = m_st_reg;
        m_val_next   = m_val_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == S_RESP && (!m_valid_reg || m_tready)) begin
            m_valid_next = 1'b1;
            m_st_next    = res_st_reg;
            m_val_next   = res_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tsize_reg   <= SIZE_RESET;
            valid_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                tsize_reg <= cfg_wdata;
            end
        end
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        n_reg       <= n_next;
        res_st_reg  <= res_st_next;
        res_val_reg <= res_val_next;
        m_st_reg    <= m_st_next;
        m_val_reg   <= m_val_next;
    end

    lpht_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (s_tdata[KEY_W-1:0]),
        .divisor   (eff_size),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Read address follows the next probe position so data lines up with pos_reg.
    lpht_mem #(
        .DEPTH (SLOT_COUNT),
        .DW    (DW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (AW'(pos_reg)),
        .wdata ({val_reg, key_reg}),
        .raddr (AW'(pos_next)),
        .rdata (mem_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_val_reg;
    assign m_tuser  = m_st_reg;

endmodule
